// File: hw/rtl/chts_pkg.sv
package chts_pkg;

    localparam int MAX_BUCKETS = 64;
    localparam int MAX_ENTRIES = 256;
    localparam int BKT_W = $clog2(MAX_BUCKETS);
    localparam int ENT_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = ENT_W + 1;
    localparam int KEY_W = 31;
    localparam int BCFG_W = 7;
    localparam int LCFG_W = 9;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W = 1;

    localparam logic [0:0] OP_INSERT = 1'b0;
    localparam logic [0:0] OP_SEARCH = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_LIMIT = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_REJECTED = 2'd1;
    localparam logic [1:0] ST_FOUND = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [0:0]       operation;
        logic [KEY_W-1:0] key;
    } t_in;

    typedef struct packed {
        logic [1:0] status;
        logic [8:0] comparisons;
    } t_out;

    // Request from the sequencer to the remainder unit, and its answer.
    typedef struct packed {
        logic             start;
        logic [KEY_W-1:0] dividend;
        logic [BCFG_W-1:0] divisor;
    } t_mod_req;

    typedef struct packed {
        logic             done;
        logic [BKT_W-1:0] remainder;
    } t_mod_rsp;

endpackage

// File: hw/rtl/chts_mod_unit.sv
module chts_mod_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  chts_pkg::t_mod_req i_req,
    output chts_pkg::t_mod_rsp o_rsp
);

    // Restoring division, one quotient bit per cycle; only the remainder is kept.
    logic [chts_pkg::KEY_W-1:0]  r_dvd, n_dvd;
    logic [chts_pkg::BCFG_W:0]   r_rem, n_rem;
    logic [chts_pkg::BCFG_W-1:0] r_dvs, n_dvs;
    logic [4:0]                  r_cnt, n_cnt;
    logic                        r_busy, n_busy;
    logic                        r_done, n_done;
    logic [chts_pkg::BCFG_W:0]   shifted;

    always_comb begin
        n_dvd  = r_dvd;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        shifted = {r_rem[chts_pkg::BCFG_W-1:0], r_dvd[chts_pkg::KEY_W-1]};
        if (i_req.start) begin
            n_dvd  = i_req.dividend;
            n_rem  = '0;
            n_dvs  = i_req.divisor;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_dvd = {r_dvd[chts_pkg::KEY_W-2:0], 1'b0};
            if (shifted >= {1'b0, r_dvs}) begin
                n_rem = shifted - {1'b0, r_dvs};
            end else begin
                n_rem = shifted;
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'(chts_pkg::KEY_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.remainder = r_rem[chts_pkg::BKT_W-1:0];

endmodule

// File: hw/rtl/chained_hash_table_insert_search_unit.sv
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_data  (operation, key)
// result    out        o_valid / i_stall  o_data  (status, comparisons)
// config    in         i_cfg_we           i_cfg_index, i_cfg_data
// One item at a time. The bucket remainder is found one bit a cycle over the 31-bit
// key, and then the bucket memory is read. An insert writes the new entry and the
// bucket, and also rewrites the old tail's link when it joins a non-empty chain; a
// search ends on an empty chain, else reads each examined entry from the entry memory.
// Reset clears the lengths' valid bits and the entry count at once; no clearing pass.
// A stalled result waits in its output register; a later one holds the input stalled.
module chained_hash_table_insert_search_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  chts_pkg::t_in                       i_data,
    output logic                                o_valid,
    input  logic                                i_stall,
    output chts_pkg::t_out                      o_data,
    input  logic                                i_cfg_we,
    input  logic [chts_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [chts_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MOD   = 4'd1;
    localparam logic [3:0] S_BRD   = 4'd2;
    localparam logic [3:0] S_BUSE  = 4'd3;
    localparam logic [3:0] S_IWR   = 4'd4;
    localparam logic [3:0] S_ERD   = 4'd5;
    localparam logic [3:0] S_ECMP  = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;

    localparam int BKT_W = chts_pkg::BKT_W;
    localparam int ENT_W = chts_pkg::ENT_W;
    localparam int CNT_W = chts_pkg::CNT_W;
    localparam int KEY_W = chts_pkg::KEY_W;

    logic [chts_pkg::BCFG_W-1:0] r_bcfg;
    logic [chts_pkg::LCFG_W-1:0] r_lcfg;
    logic [3:0]                  r_state, n_state;
    logic [0:0]                  r_op;
    logic [KEY_W-1:0]            r_key;
    logic [BKT_W-1:0]            r_bkt;
    logic [CNT_W-1:0]            r_stored;
    logic [CNT_W-1:0]            r_len;
    logic [CNT_W-1:0]            r_pos;
    logic [ENT_W-1:0]            r_last, r_cur;
    chts_pkg::t_out              r_res;
    logic                        r_ovalid;

    // Bucket memory: first, last and length of each chain.
    logic [2*ENT_W+CNT_W-1:0]    bmem [chts_pkg::MAX_BUCKETS];
    logic [2*ENT_W+CNT_W-1:0]    r_brd;
    logic [chts_pkg::MAX_BUCKETS-1:0] r_bvalid;
    logic                        r_bval_rd;
    // Entry memory: key and next link.
    logic [KEY_W+ENT_W-1:0]      emem [chts_pkg::MAX_ENTRIES];
    logic [KEY_W+ENT_W-1:0]      r_erd;

    logic                        b_we;
    logic [2*ENT_W+CNT_W-1:0]    b_wd;
    logic                        e_we;
    logic [ENT_W-1:0]            e_wa;
    logic [KEY_W+ENT_W-1:0]      e_wd;
    logic [ENT_W-1:0]            e_ra;

    chts_pkg::t_mod_req mreq;
    chts_pkg::t_mod_rsp mrsp;

    logic [chts_pkg::BCFG_W-1:0] eff_b;
    logic [chts_pkg::LCFG_W-1:0] eff_l;
    logic                        acc;
    logic [CNT_W-1:0]            blen;

    chts_mod_unit u_mod (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (mreq),
        .o_rsp  (mrsp)
    );

    always_comb begin
        if (r_bcfg == '0) begin
            eff_b = chts_pkg::BCFG_W'(1);
        end else if (r_bcfg > chts_pkg::BCFG_W'(chts_pkg::MAX_BUCKETS)) begin
            eff_b = chts_pkg::BCFG_W'(chts_pkg::MAX_BUCKETS);
        end else begin
            eff_b = r_bcfg;
        end
        if (r_lcfg > chts_pkg::LCFG_W'(chts_pkg::MAX_ENTRIES)) begin
            eff_l = chts_pkg::LCFG_W'(chts_pkg::MAX_ENTRIES);
        end else begin
            eff_l = r_lcfg;
        end
    end

    assign acc = i_valid && (r_state == S_IDLE);
    assign o_stall = (r_state != S_IDLE);
    assign mreq.start = acc;
    assign mreq.dividend = i_data.key;
    assign mreq.divisor = eff_b;
    assign blen = r_bval_rd ? r_brd[CNT_W-1:0] : '0;

    always_comb begin
        n_state = r_state;
        b_we = 1'b0;
        b_wd = '0;
        e_we = 1'b0;
        e_wa = r_stored[ENT_W-1:0];
        e_wd = {r_key, {ENT_W{1'b0}}};
        e_ra = r_cur;
        unique case (r_state)
            S_IDLE: if (acc) n_state = S_MOD;
            S_MOD:  if (mrsp.done) n_state = S_BRD;
            S_BRD:  n_state = S_BUSE;
            S_BUSE: begin
                if (r_op == chts_pkg::OP_INSERT) begin
                    if ((r_stored + 1'b1) > CNT_W'(eff_l) ||
                        r_stored >= CNT_W'(chts_pkg::MAX_ENTRIES)) begin
                        n_state = S_OUT;
                    end else begin
                        e_we = 1'b1;
                        b_we = 1'b1;
                        b_wd = {(blen == '0) ? r_stored[ENT_W-1:0]
                                             : r_brd[2*ENT_W+CNT_W-1 -: ENT_W],
                                r_stored[ENT_W-1:0], blen + 1'b1};
                        n_state = (blen == '0) ? S_OUT : S_IWR;
                    end
                end else begin
                    e_ra = r_brd[2*ENT_W+CNT_W-1 -: ENT_W];
                    n_state = (blen == '0) ? S_OUT : S_ECMP;
                end
            end
            S_IWR: begin
                // Link the previous tail to the new slot; the count has already moved on.
                e_we = 1'b1;
                e_wa = r_last;
                e_wd = {r_erd[KEY_W+ENT_W-1 -: KEY_W], ENT_W'(r_stored - 1'b1)};
                n_state = S_OUT;
            end
            S_ERD: n_state = S_ECMP;
            S_ECMP: begin
                e_ra = r_erd[ENT_W-1:0];
                if (r_erd[KEY_W+ENT_W-1 -: KEY_W] == r_key || r_pos == r_len) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_ERD;
                end
            end
            S_OUT: if (!r_ovalid || !i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (b_we) bmem[r_bkt] <= b_wd;
        r_brd <= bmem[(r_state == S_MOD) ? mrsp.remainder : r_bkt];
        if (e_we) emem[e_wa] <= e_wd;
        r_erd <= emem[(r_state == S_BUSE && r_op == chts_pkg::OP_INSERT)
                      ? r_brd[CNT_W +: ENT_W] : e_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_bcfg   <= chts_pkg::BCFG_W'(64);
            r_lcfg   <= chts_pkg::LCFG_W'(256);
            r_stored <= '0;
            r_bvalid <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    chts_pkg::REG_BUCKET_COUNT: r_bcfg <= i_cfg_data[chts_pkg::BCFG_W-1:0];
                    chts_pkg::REG_ENTRY_LIMIT:  r_lcfg <= i_cfg_data;
                    default: ;
                endcase
            end
            if (b_we) r_bvalid[r_bkt] <= 1'b1;
            if (e_we && r_state == S_BUSE) r_stored <= r_stored + 1'b1;
            if (r_state == S_OUT && (!r_ovalid || !i_stall)) begin
                r_ovalid <= 1'b1;
            end else if (o_valid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
        if (acc) begin
            r_op  <= i_data.operation;
            r_key <= i_data.key;
        end
        if (r_state == S_MOD && mrsp.done) begin
            r_bkt <= mrsp.remainder;
            r_bval_rd <= r_bvalid[mrsp.remainder];
        end
        if (r_state == S_BUSE) begin
            r_len   <= blen;
            r_pos   <= CNT_W'(1);
            r_last  <= r_brd[CNT_W +: ENT_W];
            if (r_op == chts_pkg::OP_INSERT) begin
                if ((r_stored + 1'b1) > CNT_W'(eff_l) ||
                    r_stored >= CNT_W'(chts_pkg::MAX_ENTRIES)) begin
                    r_res <= '{status: chts_pkg::ST_REJECTED, comparisons: '0};
                end else begin
                    r_res <= '{status: chts_pkg::ST_INSERTED, comparisons: '0};
                end
            end else begin
                r_res <= '{status: chts_pkg::ST_NOT_FOUND, comparisons: '0};
            end
        end
        if (r_state == S_ECMP) begin
            r_cur <= r_erd[ENT_W-1:0];
            r_pos <= r_pos + 1'b1;
            if (r_erd[KEY_W+ENT_W-1 -: KEY_W] == r_key) begin
                r_res <= '{status: chts_pkg::ST_FOUND, comparisons: 9'(r_pos)};
            end
        end
        if (r_state == S_OUT && (!r_ovalid || !i_stall)) o_data <= r_res;
    end

    assign o_valid = r_ovalid;

endmodule

// File: bench/testbench.sv
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_valid;
    logic                            o_stall;
    chts_pkg::t_in                   i_data;
    logic                            o_valid;
    logic                            i_stall;
    chts_pkg::t_out                  o_data;
    logic                            i_cfg_we;
    logic [chts_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [chts_pkg::CFG_DATA_W-1:0] i_cfg_data;

    chained_hash_table_insert_search_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Predictor state: keys in insertion order per bucket.
    logic [chts_pkg::KEY_W-1:0]  table_keys[$];
    logic [5:0]                  table_bucket[$];
    logic [chts_pkg::BCFG_W-1:0] cur_buckets;
    logic [chts_pkg::LCFG_W-1:0] cur_limit;

    chts_pkg::t_in  pending_items[$];
    chts_pkg::t_out expected_results[$];
    int   mismatch_count;
    int   stall_hold;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic chts_pkg::t_out predict_lookup(input chts_pkg::t_in item);
        int nb;
        int lim;
        int pos;
        logic [5:0] b;
        chts_pkg::t_out res;
        nb = (cur_buckets == 0) ? 1 : (cur_buckets > chts_pkg::MAX_BUCKETS
                                       ? chts_pkg::MAX_BUCKETS : cur_buckets);
        lim = (cur_limit > chts_pkg::MAX_ENTRIES) ? chts_pkg::MAX_ENTRIES : cur_limit;
        b = 6'(item.key % nb);
        res.comparisons = '0;
        if (item.operation == chts_pkg::OP_INSERT) begin
            if (table_keys.size() + 1 > lim) begin
                res.status = chts_pkg::ST_REJECTED;
            end else begin
                table_keys.insert(table_keys.size(), item.key);
                table_bucket.insert(table_bucket.size(), b);
                res.status = chts_pkg::ST_INSERTED;
            end
        end else begin
            res.status = chts_pkg::ST_NOT_FOUND;
            pos = 0;
            // Chains keep the bucket recorded at insert time.
            foreach (table_keys[i]) begin
                if (table_bucket[i] == b) begin
                    pos++;
                    if (table_keys[i] == item.key) begin
                        res.status = chts_pkg::ST_FOUND;
                        res.comparisons = 9'(pos);
                        break;
                    end
                end
            end
        end
        return res;
    endfunction

    // Driver: gaps of random length between transfers.
    int gap_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            gap_left <= 0;
        end else if (i_valid && !o_stall) begin
            expected_results.insert(expected_results.size(), predict_lookup(i_data));
            if (pending_items.size() > 0 && $urandom_range(0, 2) != 0) begin
                i_data <= pending_items.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
                gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 120)
                                                         : $urandom_range(0, 3);
            end
        end else if (!i_valid) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (pending_items.size() > 0) begin
                i_data <= pending_items.pop_front();
                i_valid <= 1'b1;
            end
        end
    end

    // Receiver stall and monitor.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result %0d/%0d", o_data.status, o_data.comparisons);
                end else begin
                    chts_pkg::t_out exp_res;
                    exp_res = expected_results.pop_front();
                    if (exp_res.status !== o_data.status
                        || exp_res.comparisons !== o_data.comparisons) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("result mismatch: expected %0d/%0d, got %0d/%0d",
                                     exp_res.status, exp_res.comparisons,
                                     o_data.status, o_data.comparisons);
                    end
                end
            end
            if (stall_hold > 0) begin
                stall_hold <= stall_hold - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    task automatic write_reg(input logic [chts_pkg::CFG_IDX_W-1:0] idx, input int value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value[chts_pkg::CFG_DATA_W-1:0];
        cur_buckets = (idx == chts_pkg::REG_BUCKET_COUNT) ? value[chts_pkg::BCFG_W-1:0]
                                                         : cur_buckets;
        cur_limit = (idx == chts_pkg::REG_ENTRY_LIMIT) ? value[chts_pkg::LCFG_W-1:0]
                                                       : cur_limit;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain_all;
        while (pending_items.size() > 0 || i_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic chts_pkg::t_in make_item(input logic op,
                                                input logic [chts_pkg::KEY_W-1:0] key);
        chts_pkg::t_in item;
        item.operation = op;
        item.key = key;
        return item;
    endfunction

    task automatic queue_item(input logic op, input logic [chts_pkg::KEY_W-1:0] key);
        pending_items.insert(pending_items.size(), make_item(op, key));
    endtask

    // Random phase: inserts and searches, with searches often hitting stored keys.
    task automatic random_phase(input int count, input int key_span);
        chts_pkg::t_in item;
        logic [chts_pkg::KEY_W-1:0] recent[$];
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 1) == 0 || recent.size() == 0) begin
                item = make_item(chts_pkg::OP_INSERT, ($urandom_range(0, 3) == 0)
                    ? chts_pkg::KEY_W'($urandom)
                    : chts_pkg::KEY_W'($urandom_range(0, key_span)));
                recent.insert(recent.size(), item.key);
            end else if ($urandom_range(0, 3) != 0) begin
                item = make_item(chts_pkg::OP_SEARCH,
                                 recent[$urandom_range(0, recent.size() - 1)]);
            end else begin
                item = make_item(chts_pkg::OP_SEARCH, ($urandom_range(0, 1) == 0)
                    ? chts_pkg::KEY_W'($urandom)
                    : chts_pkg::KEY_W'($urandom_range(0, key_span)));
            end
            pending_items.insert(pending_items.size(), item);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        cur_buckets = 64;
        cur_limit = 256;
        mismatch_count = 0;
        stall_hold = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: key extremes, duplicates, search before insert.
        queue_item(chts_pkg::OP_SEARCH, 31'd0);
        queue_item(chts_pkg::OP_INSERT, 31'd0);
        queue_item(chts_pkg::OP_INSERT, 31'h7FFF_FFFF);
        queue_item(chts_pkg::OP_INSERT, 31'd64);
        queue_item(chts_pkg::OP_INSERT, 31'd0);
        queue_item(chts_pkg::OP_SEARCH, 31'd0);
        queue_item(chts_pkg::OP_SEARCH, 31'd64);
        queue_item(chts_pkg::OP_SEARCH, 31'h7FFF_FFFF);
        queue_item(chts_pkg::OP_SEARCH, 31'h5555_5555);
        queue_item(chts_pkg::OP_SEARCH, 31'h2AAA_AAAA);
        drain_all();

        // Zero bucket count acts as one bucket; then change modulus with keys stored.
        write_reg(chts_pkg::REG_BUCKET_COUNT, 0);
        queue_item(chts_pkg::OP_INSERT, 31'd7);
        queue_item(chts_pkg::OP_SEARCH, 31'd7);
        queue_item(chts_pkg::OP_SEARCH, 31'd64);
        drain_all();
        write_reg(chts_pkg::REG_BUCKET_COUNT, 127);
        write_reg(chts_pkg::REG_ENTRY_LIMIT, 511);
        queue_item(chts_pkg::OP_SEARCH, 31'd7);
        queue_item(chts_pkg::OP_SEARCH, 31'd64);
        // Long receiver hold while items keep coming.
        random_phase(40, 300);
        stall_hold = 300;
        drain_all();

        // Limit zero rejects every insert.
        write_reg(chts_pkg::REG_ENTRY_LIMIT, 0);
        queue_item(chts_pkg::OP_INSERT, 31'd3);
        queue_item(chts_pkg::OP_SEARCH, 31'd3);
        drain_all();

        // Main random phases. Reset is not repeated, so the table grows until full.
        write_reg(chts_pkg::REG_ENTRY_LIMIT, 200);
        write_reg(chts_pkg::REG_BUCKET_COUNT, 5);
        random_phase(400, 100);
        drain_all();
        write_reg(chts_pkg::REG_BUCKET_COUNT, 1);
        random_phase(300, 50);
        drain_all();
        write_reg(chts_pkg::REG_ENTRY_LIMIT, 256);
        write_reg(chts_pkg::REG_BUCKET_COUNT, 64);
        random_phase(600, 1000);
        drain_all();
        write_reg(chts_pkg::REG_BUCKET_COUNT, 13);
        random_phase(560, 500);
        drain_all();
        repeat (50) @(posedge i_clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #50ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
